// ----- hdl/efe_pkg.sv -----
`timescale 1ns / 1ps
package efe_pkg;

  // frame layout
  localparam int ID_W       = 40;
  localparam int NIB_W      = 4;
  localparam int ROW_COUNT  = 10;
  localparam int HDR_BITS   = 9;
  localparam int FRAME_BITS = 64;
  localparam int POS_W      = 6;
  localparam int ROW_W      = NIB_W + 1;

  // frame queue between front and back
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = 1;
  localparam int QCOUNT_W = 2;

  typedef logic [FRAME_BITS-1:0] efe_frame_t;
  typedef logic [ID_W-1:0]       efe_id_t;
  typedef logic [POS_W-1:0]      efe_pos_t;

  // queue status seen by the serializer
  typedef struct packed {
    logic empty;
    logic full;
  } efe_q_status_t;

  localparam efe_pos_t LAST_POS = efe_pos_t'(FRAME_BITS - 1);

endpackage

// ----- hdl/em410x_frame_encoder.sv -----
`timescale 1ns / 1ps
// EM410x frame encoder: one 40-bit tag id in, its 64-bit tag frame out,
// one frame bit per result transaction.
// Input channel: present tag_id with push; the transaction is taken at a
// clock edge with push high and full low. Id bits 39..36 follow the header.
// Result channel: while empty is low the ports show the oldest frame bit,
// its inverted second Manchester half, its position 0..63 and last_bit on
// the stop bit; pop high with empty low takes it.
// With the block idle, a taken id goes into the frame queue and from there
// into the output register, which shows bit 0. The serializer sends one bit
// per cycle while the receiver takes them; frames follow with no gap.
// The front builds the frame combinationally and writes it into a two-entry
// frame queue, so up to two more ids are taken while a frame is sent.
// When the receiver stalls, the output bit holds and the serializer waits;
// full rises once the queue holds two frames.
// Reset (synchronous, rst high) empties the queue and the output register.
module em410x_frame_encoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  efe_pkg::efe_id_t    tag_id,
  output logic                empty,
  input  logic                pop,
  output logic                frame_bit,
  output logic                second_half_level,
  output efe_pkg::efe_pos_t   bit_position,
  output logic                last_bit
);
  import efe_pkg::*;

  efe_frame_t    built_frame;
  efe_frame_t    q_frame;
  efe_q_status_t q_status;
  logic          q_pop;

  // front: frame assembly
  efe_frame_builder u_builder (
    .tag_id (tag_id),
    .frame  (built_frame)
  );

  // queue between front and back
  efe_frame_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_frame (built_frame),
    .rd_en    (q_pop),
    .rd_frame (q_frame),
    .status   (q_status)
  );

  assign full = q_status.full;

  // back: bit serializer
  efe_serializer u_serializer (
    .clk               (clk),
    .rst               (rst),
    .q_status          (q_status),
    .q_frame           (q_frame),
    .q_pop             (q_pop),
    .pop               (pop),
    .empty             (empty),
    .frame_bit         (frame_bit),
    .second_half_level (second_half_level),
    .bit_position      (bit_position),
    .last_bit          (last_bit)
  );

  // last_bit marks exactly the stop position
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (last_bit == (bit_position == LAST_POS)))
    else $error("last_bit does not match stop position");

  // second half is always the inverse of the frame bit
  a_manchester: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (second_half_level != frame_bit))
    else $error("manchester halves not complementary");

  // within a frame, the next bit follows right after a taken bit
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last_bit) |=>
      (!empty && bit_position == $past(bit_position) + POS_W'(1)))
    else $error("frame bits not contiguous");

  // a stop bit is followed by position zero or an empty output
  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && last_bit) |=> (empty || bit_position == '0))
    else $error("new frame does not start at position zero");

endmodule

// ----- hdl/efe_frame_builder.sv -----
`timescale 1ns / 1ps
module efe_frame_builder (
  input  efe_pkg::efe_id_t   tag_id,
  output efe_pkg::efe_frame_t frame
);
  import efe_pkg::*;

  logic [NIB_W-1:0] nib [ROW_COUNT];
  logic [NIB_W-1:0] col;

  // split the id into rows, most significant nibble first
  always_comb begin
    for (int r = 0; r < ROW_COUNT; r++) begin
      nib[r] = tag_id[ID_W - 1 - NIB_W*r -: NIB_W];
    end
  end

  // column parity, xor of all row nibbles
  always_comb begin
    col = '0;
    for (int r = 0; r < ROW_COUNT; r++) begin
      col = col ^ nib[r];
    end
  end

  // header ones, rows with even parity, column parity, stop zero
  always_comb begin
    frame = '0;
    frame[FRAME_BITS-1 -: HDR_BITS] = '1;
    for (int r = 0; r < ROW_COUNT; r++) begin
      frame[FRAME_BITS - 1 - HDR_BITS - ROW_W*r -: ROW_W] = {nib[r], ^nib[r]};
    end
    frame[NIB_W:1] = col;
    frame[0]       = 1'b0;
  end

endmodule

// ----- hdl/efe_frame_queue.sv -----
`timescale 1ns / 1ps
module efe_frame_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  efe_pkg::efe_frame_t   wr_frame,
  input  logic                  rd_en,
  output efe_pkg::efe_frame_t   rd_frame,
  output efe_pkg::efe_q_status_t status
);
  import efe_pkg::*;

  efe_frame_t          entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCOUNT_W-1:0] count;
  logic                do_wr;
  logic                do_rd;

  assign status.empty = (count == '0);
  assign status.full  = (count == QCOUNT_W'(QDEPTH));
  assign do_wr        = wr_en && !status.full;
  assign do_rd        = rd_en && !status.empty;
  assign rd_frame     = entries[rd_ptr];

  // frame storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_frame;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + QCOUNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - QCOUNT_W'(1);
      end
    end
  end

endmodule

// ----- hdl/efe_serializer.sv -----
`timescale 1ns / 1ps
module efe_serializer (
  input  logic                   clk,
  input  logic                   rst,
  input  efe_pkg::efe_q_status_t q_status,
  input  efe_pkg::efe_frame_t    q_frame,
  output logic                   q_pop,
  input  logic                   pop,
  output logic                   empty,
  output logic                   frame_bit,
  output logic                   second_half_level,
  output efe_pkg::efe_pos_t      bit_position,
  output logic                   last_bit
);
  import efe_pkg::*;

  efe_frame_t shift;
  efe_pos_t   count;
  logic       active;
  logic       out_valid;
  logic       out_load;

  // output register can take a new bit when empty or being drained
  assign out_load = !out_valid || pop;
  assign q_pop    = out_load && !active && !q_status.empty;
  assign empty    = !out_valid;

  // shift out one frame bit per cycle into the output register while it can load
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else if (out_load) begin
      if (active) begin
        frame_bit         <= shift[FRAME_BITS-1];
        second_half_level <= !shift[FRAME_BITS-1];
        bit_position      <= count;
        last_bit          <= (count == LAST_POS);
        shift             <= {shift[FRAME_BITS-2:0], 1'b0};
        count             <= count + POS_W'(1);
        active            <= (count != LAST_POS);
        out_valid         <= 1'b1;
      end else if (!q_status.empty) begin
        frame_bit         <= q_frame[FRAME_BITS-1];
        second_half_level <= !q_frame[FRAME_BITS-1];
        bit_position      <= '0;
        last_bit          <= 1'b0;
        shift             <= {q_frame[FRAME_BITS-2:0], 1'b0};
        count             <= POS_W'(1);
        active            <= 1'b1;
        out_valid         <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
